[rtl/utf8_stream_decoder_macros.svh]
// Assertion macros for the UTF-8 stream decoder.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// A condition that must hold at every rising clock edge outside reset.
`define U8SD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// An implication checked in the same cycle.
`define U8SD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define U8SD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/u8sd_pkg.sv]
// Package for the UTF-8 stream decoder: result type and byte class constants.
// No dependencies.
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int unsigned CpWidth  = 21;
    localparam int unsigned LenWidth = 3;

    // Upper bounds of the byte classes.
    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MAX = 8'hF7;

    // Continuation byte pattern and payload masks.
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] CONT_MASK  = 8'h3F;
    localparam logic [7:0] LEAD2_MASK = 8'h1F;
    localparam logic [7:0] LEAD3_MASK = 8'h0F;
    localparam logic [7:0] LEAD4_MASK = 8'h07;

    typedef struct packed {
        logic [CpWidth-1:0]  code_point;
        logic [LenWidth-1:0] num_bytes;
        logic                is_error;
        logic                end_of_string;
        logic                string_valid;
    } result_t;

endpackage

[rtl/utf8_stream_decoder.sv]
// UTF-8 stream decoder: the result of an accepted byte is registered before it shows on m_*.
// Throughput one byte per cycle; an output register plus a skid register keep
// s_ready high while one result waits, so only a second waiting result stalls input.
// aresetn (synchronous, active low) clears the decode state and empties both
// output registers.
// Uses u8sd_pkg and utf8_stream_decoder_macros.svh.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [20:0] m_code_point,
    output logic [2:0]  m_num_bytes,
    output logic        m_is_error,
    output logic        m_end_of_string,
    output logic        m_string_valid
);

    // Decode state.
    logic [1:0]                        pending_reg, pending_next;
    logic [u8sd_pkg::CpWidth-1:0]      accum_reg, accum_next;
    logic [u8sd_pkg::LenWidth-1:0]     seq_len_reg, seq_len_next;
    logic                              err_seen_reg, err_seen_next;

    // Output register and skid register.
    u8sd_pkg::result_t out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;

    u8sd_pkg::result_t res;
    logic              res_valid;
    logic              accept;
    logic [7:0]        b;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign b       = s_byte_in;

    always_comb begin
        pending_next  = pending_reg;
        accum_next    = accum_reg;
        seq_len_next  = seq_len_reg;
        err_seen_next = err_seen_reg;
        res           = '0;
        res_valid     = 1'b0;

        if (b == 8'h00) begin
            // A zero byte closes the string whatever came before.
            res_valid         = 1'b1;
            res.end_of_string = 1'b1;
            priority if (err_seen_reg) begin
                res.string_valid = 1'b0;
            end else if (pending_reg != 2'd0) begin
                res.is_error = 1'b1;
            end else begin
                res.string_valid = 1'b1;
            end
            pending_next  = '0;
            accum_next    = '0;
            seq_len_next  = '0;
            err_seen_next = 1'b0;
        end else if (err_seen_reg) begin
            // Silent until the end of the string.
            res_valid = 1'b0;
        end else if (pending_reg == 2'd0) begin
            priority if (b <= u8sd_pkg::ASCII_MAX) begin
                res_valid       = 1'b1;
                res.code_point  = {13'd0, b};
                res.num_bytes   = 3'd1;
            end else if (b <= u8sd_pkg::CONT_MAX) begin
                res_valid     = 1'b1;
                res.is_error  = 1'b1;
                err_seen_next = 1'b1;
            end else if (b <= u8sd_pkg::LEAD2_MAX) begin
                accum_next   = {13'd0, b & u8sd_pkg::LEAD2_MASK};
                pending_next = 2'd1;
                seq_len_next = 3'd2;
            end else if (b <= u8sd_pkg::LEAD3_MAX) begin
                accum_next   = {13'd0, b & u8sd_pkg::LEAD3_MASK};
                pending_next = 2'd2;
                seq_len_next = 3'd3;
            end else if (b <= u8sd_pkg::LEAD4_MAX) begin
                accum_next   = {13'd0, b & u8sd_pkg::LEAD4_MASK};
                pending_next = 2'd3;
                seq_len_next = 3'd4;
            end else begin
                res_valid     = 1'b1;
                res.is_error  = 1'b1;
                err_seen_next = 1'b1;
            end
        end else if ((b & ~u8sd_pkg::CONT_MASK) != u8sd_pkg::CONT_TAG) begin
            // A bad follower drops the partial sequence.
            res_valid     = 1'b1;
            res.is_error  = 1'b1;
            err_seen_next = 1'b1;
            pending_next  = '0;
            accum_next    = '0;
            seq_len_next  = '0;
        end else if (pending_reg == 2'd1) begin
            res_valid       = 1'b1;
            res.code_point  = {accum_reg[14:0], b[5:0]};
            res.num_bytes   = seq_len_reg;
            pending_next    = '0;
            accum_next      = '0;
            seq_len_next    = '0;
        end else begin
            accum_next   = {accum_reg[14:0], b[5:0]};
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= '0;
            accum_reg    <= '0;
            seq_len_reg  <= '0;
            err_seen_reg <= 1'b0;
        end else if (accept) begin
            pending_reg  <= pending_next;
            accum_reg    <= accum_next;
            seq_len_reg  <= seq_len_next;
            err_seen_reg <= err_seen_next;
        end
    end

    // The skid register only fills when the output register is stalled, and it
    // drains into the output register before any new transaction is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept && res_valid;
            end
        end else if (accept && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept && res_valid) begin
                out_reg <= res;
            end
        end else if (accept && res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_code_point    = out_reg.code_point;
    assign m_num_bytes     = out_reg.num_bytes;
    assign m_is_error      = out_reg.is_error;
    assign m_end_of_string = out_reg.end_of_string;
    assign m_string_valid  = out_reg.string_valid;

    `U8SD_ASSERT_IMPLY(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid full with empty output")
    `U8SD_ASSERT_ALWAYS(a_len_tracks_pending,
        (pending_reg != 2'd0) == (seq_len_reg != 3'd0),
        "sequence length and pending count disagree")
    `U8SD_ASSERT_IMPLY(a_no_seq_after_error, err_seen_reg, pending_reg == 2'd0,
        "sequence open after an error")
    `U8SD_ASSERT_IMPLY(a_error_no_char, m_valid && (m_is_error || m_end_of_string),
        m_num_bytes == 3'd0 && m_code_point == 21'd0,
        "error or end result carries a character")
    `U8SD_ASSERT_NEXT(a_stall_fills_skid, m_valid && !m_ready && accept && res_valid,
        skid_valid_reg, "result lost while output stalled")

endmodule

[tb/utf8_stream_decoder_tb.sv]
// Self-checking testbench for utf8_stream_decoder: directed and random byte strings,
// predicted per byte and compared against every result transaction.
// Depends on u8sd_pkg and the utf8_stream_decoder RTL.
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;

    typedef struct packed {
        bit         wait_idle;
        logic [7:0] value;
    } text_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_in = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [20:0] m_code_point;
    logic [2:0]  m_num_bytes;
    logic        m_is_error;
    logic        m_end_of_string;
    logic        m_string_valid;

    // Decoder state as the predictor sees it.
    logic [1:0]  dec_pending = '0;
    logic [20:0] dec_accum = '0;
    logic [2:0]  dec_len = '0;
    logic        dec_err_seen = 1'b0;

    text_byte_t         text_bytes[$];
    u8sd_pkg::result_t  decoded_results[$];
    u8sd_pkg::result_t  oldest_result;

    int fail_count = 0;
    int bytes_sent = 0;
    int strings_built = 0;
    int chars_seen = 0;
    int errors_seen = 0;
    int ends_seen = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int ready_pct = 100;
    int pattern_left = 0;
    bit long_hold_done = 1'b0;
    bit drain_marked = 1'b0;

    utf8_stream_decoder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_in      (s_byte_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_code_point   (m_code_point),
        .m_num_bytes    (m_num_bytes),
        .m_is_error     (m_is_error),
        .m_end_of_string(m_end_of_string),
        .m_string_valid (m_string_valid)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Advances the decoder state by one byte and queues the result it produces, if any.
    function automatic void utf8_decode_byte(input logic [7:0] b);
        u8sd_pkg::result_t r;
        bit      emit;
        bit      bad;
        r = '0;
        emit = 1'b0;
        bad = 1'b0;
        if (b == 8'h00) begin
            emit = 1'b1;
            r.end_of_string = 1'b1;
            if (!dec_err_seen) begin
                if (dec_pending != 0) r.is_error = 1'b1;
                else r.string_valid = 1'b1;
            end
            dec_pending = '0;
            dec_accum = '0;
            dec_len = '0;
            dec_err_seen = 1'b0;
        end else if (dec_err_seen) begin
            emit = 1'b0;
        end else if (dec_pending == 0) begin
            if (b <= u8sd_pkg::ASCII_MAX) begin
                emit = 1'b1;
                r.code_point = 21'(b);
                r.num_bytes = 3'd1;
            end else if (b <= u8sd_pkg::CONT_MAX) begin
                bad = 1'b1;
            end else if (b <= u8sd_pkg::LEAD2_MAX) begin
                dec_accum = 21'(b & u8sd_pkg::LEAD2_MASK);
                dec_pending = 2'd1;
                dec_len = 3'd2;
            end else if (b <= u8sd_pkg::LEAD3_MAX) begin
                dec_accum = 21'(b & u8sd_pkg::LEAD3_MASK);
                dec_pending = 2'd2;
                dec_len = 3'd3;
            end else if (b <= u8sd_pkg::LEAD4_MAX) begin
                dec_accum = 21'(b & u8sd_pkg::LEAD4_MASK);
                dec_pending = 2'd3;
                dec_len = 3'd4;
            end else begin
                bad = 1'b1;
            end
        end else if ((b & ~u8sd_pkg::CONT_MASK) != u8sd_pkg::CONT_TAG) begin
            bad = 1'b1;
        end else begin
            dec_accum = {dec_accum[14:0], b[5:0]};
            dec_pending = dec_pending - 2'd1;
            if (dec_pending == 0) begin
                emit = 1'b1;
                r.code_point = dec_accum;
                r.num_bytes = dec_len;
                dec_accum = '0;
                dec_len = '0;
            end
        end
        if (bad) begin
            emit = 1'b1;
            r.is_error = 1'b1;
            dec_pending = '0;
            dec_accum = '0;
            dec_len = '0;
            dec_err_seen = 1'b1;
        end
        if (emit) decoded_results.push_back(r);
    endfunction

    task automatic add_byte(input logic [7:0] value);
        text_byte_t t;
        t.value = value;
        t.wait_idle = 1'b0;
        // Once past the middle of the run, one byte waits until the output has drained.
        if (!drain_marked && text_bytes.size() >= 450 && strings_built > 20) begin
            t.wait_idle = 1'b1;
            drain_marked = 1'b1;
        end
        text_bytes.push_back(t);
    endtask

    task automatic add_string(input logic [7:0] str[]);
        foreach (str[i]) add_byte(str[i]);
        strings_built++;
    endtask

    function automatic logic [7:0] follower_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    // Queues the lead byte and the first count followers of a character of the given length.
    task automatic add_char(input int len, input int count);
        logic [7:0] lead;
        case (len)
            1: lead = 8'($urandom_range(1, 127));
            2: lead = {3'b110, 5'($urandom)};
            3: lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
        endcase
        add_byte(lead);
        for (int i = 0; i < count && i < len - 1; i++) add_byte(follower_byte());
    endtask

    task automatic add_random_string();
        int kind;
        int nchars;
        int len;
        kind = $urandom_range(0, 9);
        nchars = $urandom_range(0, 12);
        for (int i = 0; i < nchars; i++) begin
            len = $urandom_range(1, 4);
            add_char(len, len - 1);
        end
        case (kind)
            7: begin
                // String ends inside a sequence.
                len = $urandom_range(2, 4);
                add_char(len, $urandom_range(0, len - 2));
            end
            8: begin
                // A follower that is not a continuation byte, then some more text.
                len = $urandom_range(2, 4);
                add_char(len, $urandom_range(0, len - 2));
                if ($urandom_range(0, 1) == 0) add_byte(8'($urandom_range(1, 127)));
                else add_byte(8'($urandom_range(192, 255)));
                for (int i = $urandom_range(0, 4); i > 0; i--)
                    add_byte(8'($urandom_range(1, 255)));
            end
            9: begin
                for (int i = $urandom_range(1, 8); i > 0; i--)
                    add_byte(8'($urandom_range(1, 255)));
            end
            default: ;
        endcase
        add_byte(8'h00);
        strings_built++;
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                utf8_decode_byte(s_byte_in);
                bytes_sent++;
            end
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (text_bytes.size() == 0 ||
                         (text_bytes[0].wait_idle && decoded_results.size() != 0)) begin
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_byte_in <= text_bytes[0].value;
                void'(text_bytes.pop_front());
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Receiver: stall rate is redrawn whenever a random pattern length runs out; one long hold mid-run.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!long_hold_done && bytes_sent >= 300) begin
            long_hold_done = 1'b1;
            hold_left = 200;
            m_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 50;
                    default: ready_pct = 20;
                endcase
            end else begin
                pattern_left--;
            end
            m_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    task automatic check_field(input string name, input logic [20:0] want,
                               input logic [20:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Monitor: every result transaction is matched against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (decoded_results.size() == 0) begin
                $display("%0t: unexpected result, code 0x%0h bytes %0d error %0b end %0b",
                         $time, m_code_point, m_num_bytes, m_is_error, m_end_of_string);
                fail_count++;
            end else begin
                oldest_result = decoded_results.pop_front();
                check_field("code_point", oldest_result.code_point, m_code_point);
                check_field("num_bytes", 21'(oldest_result.num_bytes), 21'(m_num_bytes));
                check_field("is_error", 21'(oldest_result.is_error), 21'(m_is_error));
                check_field("end_of_string", 21'(oldest_result.end_of_string),
                            21'(m_end_of_string));
                check_field("string_valid", 21'(oldest_result.string_valid),
                            21'(m_string_valid));
            end
            if (m_end_of_string === 1'b1) ends_seen++;
            else if (m_is_error === 1'b1) errors_seen++;
            else chars_seen++;
        end
    end

    initial begin
        // Short strings that hit each byte class, several of the range ends and every special case.
        add_string('{8'h01, 8'h7F, 8'hDF, 8'hBF, 8'h00});
        add_string('{8'hE0, 8'h80, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00});
        add_string('{8'h80, 8'hFF, 8'h00});
        add_string('{8'hF8, 8'h00});
        add_string('{8'hC2, 8'h41, 8'h00});
        add_string('{8'hE2, 8'h82, 8'h00});
        add_string('{8'h00});
        while (text_bytes.size() < 730) add_random_string();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (text_bytes.size() != 0 || s_valid) @(posedge aclk);
        while (decoded_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d bytes in %0d strings under bursty input and output stalls.",
                 bytes_sent, strings_built);
        $display("Checked %0d characters, %0d errors and %0d string ends.",
                 chars_seen, errors_seen, ends_seen);
        if (fail_count == 0) begin
            $display("utf8_stream_decoder test passed");
        end else begin
            $display("utf8_stream_decoder test failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Timeout with %0d results still expected", decoded_results.size());
        $display("utf8_stream_decoder test failed");
        $finish;
    end

endmodule

[utf8_stream_decoder.f]
+incdir+rtl
rtl/u8sd_pkg.sv
rtl/utf8_stream_decoder.sv
tb/utf8_stream_decoder_tb.sv
